### sv/point_in_mesh_ray_parity_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the point-in-mesh ray parity block
// Clocked, reset-qualified implication checks shared by the checker.
// ---------------------------------------------------------------------------
`ifndef POINT_IN_MESH_RAY_PARITY_MACROS_SVH
`define POINT_IN_MESH_RAY_PARITY_MACROS_SVH

// same-cycle implication
`define PIMRP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pimrp: same-cycle check failed");

// next-cycle implication
`define PIMRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pimrp: next-cycle check failed");

`endif

### sv/pimrp_pkg.sv
// ---------------------------------------------------------------------------
// pimrp_pkg
// Shared constants and types for the point-in-mesh ray parity block.
// ---------------------------------------------------------------------------
`default_nettype none

package pimrp_pkg;

    // register port geometry
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Z = 2'd2;

    // queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

### sv/pimrp_front.sv
// ---------------------------------------------------------------------------
// pimrp_front
// Accepts triangles, forms edge vectors and the point offset, and hands the
// registered result to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module pimrp_front
    import pimrp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_v0_x,
    input  logic signed [COORD_BITS-1:0] s_v0_y,
    input  logic signed [COORD_BITS-1:0] s_v0_z,
    input  logic signed [COORD_BITS-1:0] s_v1_x,
    input  logic signed [COORD_BITS-1:0] s_v1_y,
    input  logic signed [COORD_BITS-1:0] s_v1_z,
    input  logic signed [COORD_BITS-1:0] s_v2_x,
    input  logic signed [COORD_BITS-1:0] s_v2_y,
    input  logic signed [COORD_BITS-1:0] s_v2_z,
    input  logic                         s_last_triangle,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  queue_stat_t                  queue_stat,
    output logic                         push,
    output logic [9*(COORD_BITS+1):0]    push_data
);

    localparam int D      = COORD_BITS + 1;
    localparam int ITEM_W = 9 * D + 1;

    logic signed [D-1:0] e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
    logic                valid_reg, valid_next;
    logic [ITEM_W-1:0]   item_reg, item_next;
    logic                take;

    // exact differences, one bit wider than the coordinates
    assign e1x = D'(s_v1_x) - D'(s_v0_x);
    assign e1y = D'(s_v1_y) - D'(s_v0_y);
    assign e1z = D'(s_v1_z) - D'(s_v0_z);
    assign e2x = D'(s_v2_x) - D'(s_v0_x);
    assign e2y = D'(s_v2_y) - D'(s_v0_y);
    assign e2z = D'(s_v2_z) - D'(s_v0_z);
    assign sx  = D'(point_x) - D'(s_v0_x);
    assign sy  = D'(point_y) - D'(s_v0_y);
    assign sz  = D'(point_z) - D'(s_v0_z);

    // stage register drains into the queue
    assign push    = valid_reg && !queue_stat.full;
    assign s_ready = !valid_reg || !queue_stat.full;
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (push) begin
            valid_next = 1'b0;
        end
        if (take) begin
            valid_next = 1'b1;
            item_next  = {s_last_triangle, sz, sy, sx, e2z, e2y, e2x, e1z, e1y, e1x};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign push_data = item_reg;

endmodule

`default_nettype wire

### sv/pimrp_queue.sv
// ---------------------------------------------------------------------------
// pimrp_queue
// Two-entry queue that decouples the front end from the arithmetic back end.
// ---------------------------------------------------------------------------
`default_nettype none

module pimrp_queue
    import pimrp_pkg::*;
#(
    parameter int ITEM_W = 154
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [ITEM_W-1:0] push_data,
    input  logic              pop,
    output logic [ITEM_W-1:0] head_data,
    output queue_stat_t       stat
);

    logic [ITEM_W-1:0]      mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign stat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = mem[rd_ptr_reg];

endmodule

`default_nettype wire

### sv/pimrp_back.sv
// ---------------------------------------------------------------------------
// pimrp_back
// Stalling arithmetic pipeline: cross products, determinant and barycentric
// numerators, split triple product, inclusive range checks and parity.
// ---------------------------------------------------------------------------
`default_nettype none

module pimrp_back
    import pimrp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  queue_stat_t               queue_stat,
    input  logic [9*(COORD_BITS+1):0] head_data,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_hit,
    output logic                      m_inside_parity,
    output logic                      m_verdict_valid
);

    localparam int D  = COORD_BITS + 1;   // difference width
    localparam int P  = 2 * D;            // product width
    localparam int C  = 2 * D + 1;        // cross product width
    localparam int L  = D;                // low slice of a normal component
    localparam int HW = C - L;            // high slice width
    localparam int PL = D + L + 1;        // low partial product width
    localparam int PH = D + HW;           // high partial product width
    localparam int T  = 3 * D + 3;        // triple product width

    logic en;

    // head of queue
    logic signed [D-1:0] h_e1x, h_e1y, h_e1z, h_e2x, h_e2y, h_e2z, h_sx, h_sy, h_sz;
    logic                h_last;

    assign {h_last, h_sz, h_sy, h_sx, h_e2z, h_e2y, h_e2x, h_e1z, h_e1y, h_e1x} = head_data;

    // whole pipeline advances when the output register can load
    assign en  = !m_valid || m_ready;
    assign pop = en && !queue_stat.empty;

    // stage 1: all first-level products
    logic                v1_reg;
    logic signed [P-1:0] p_e1z_e2y_reg, p_e1y_e2z_reg, p_sz_e2y_reg, p_sy_e2z_reg;
    logic signed [P-1:0] p_sy_e1z_reg, p_sz_e1y_reg, p_e1z_e2x_reg, p_e1x_e2z_reg;
    logic signed [P-1:0] p_e1x_e2y_reg, p_e1y_e2x_reg;
    logic signed [D-1:0] s1_sx_reg, s1_sy_reg, s1_sz_reg;
    logic                s1_last_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_e1z_e2y_reg <= P'(h_e1z) * P'(h_e2y);
            p_e1y_e2z_reg <= P'(h_e1y) * P'(h_e2z);
            p_sz_e2y_reg  <= P'(h_sz) * P'(h_e2y);
            p_sy_e2z_reg  <= P'(h_sy) * P'(h_e2z);
            p_sy_e1z_reg  <= P'(h_sy) * P'(h_e1z);
            p_sz_e1y_reg  <= P'(h_sz) * P'(h_e1y);
            p_e1z_e2x_reg <= P'(h_e1z) * P'(h_e2x);
            p_e1x_e2z_reg <= P'(h_e1x) * P'(h_e2z);
            p_e1x_e2y_reg <= P'(h_e1x) * P'(h_e2y);
            p_e1y_e2x_reg <= P'(h_e1y) * P'(h_e2x);
            s1_sx_reg     <= h_sx;
            s1_sy_reg     <= h_sy;
            s1_sz_reg     <= h_sz;
            s1_last_reg   <= h_last;
        end
    end

    // stage 2: normal vector and barycentric numerators
    logic                v2_reg;
    logic signed [C-1:0] nx_reg, ny_reg, nz_reg, un_reg, vn_reg;
    logic signed [D-1:0] s2_sx_reg, s2_sy_reg, s2_sz_reg;
    logic                s2_last_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg      <= C'(p_e1y_e2z_reg) - C'(p_e1z_e2y_reg);
            ny_reg      <= C'(p_e1z_e2x_reg) - C'(p_e1x_e2z_reg);
            nz_reg      <= C'(p_e1x_e2y_reg) - C'(p_e1y_e2x_reg);
            un_reg      <= C'(p_sz_e2y_reg) - C'(p_sy_e2z_reg);
            vn_reg      <= C'(p_sy_e1z_reg) - C'(p_sz_e1y_reg);
            s2_sx_reg   <= s1_sx_reg;
            s2_sy_reg   <= s1_sy_reg;
            s2_sz_reg   <= s1_sz_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: sign normalization and split partial products of s . n
    logic                v3_reg;
    logic                flip;
    logic signed [C-1:0] a_norm, un_norm, vn_norm;
    logic signed [C-1:0] a_n_reg, un_n_reg, vn_n_reg;
    logic                a_zero_reg, flip_reg, s3_last_reg;
    logic signed [PL-1:0] pl_x_reg, pl_y_reg, pl_z_reg;
    logic signed [PH-1:0] ph_x_reg, ph_y_reg, ph_z_reg;

    // determinant is -nx; it is negative exactly when nx is positive
    assign flip    = !nx_reg[C-1] && (nx_reg != '0);
    assign a_norm  = flip ? nx_reg : -nx_reg;
    assign un_norm = flip ? -un_reg : un_reg;
    assign vn_norm = flip ? -vn_reg : vn_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_n_reg     <= a_norm;
            un_n_reg    <= un_norm;
            vn_n_reg    <= vn_norm;
            a_zero_reg  <= (nx_reg == '0);
            flip_reg    <= flip;
            s3_last_reg <= s2_last_reg;
            pl_x_reg    <= PL'(s2_sx_reg) * PL'($signed({1'b0, nx_reg[L-1:0]}));
            pl_y_reg    <= PL'(s2_sy_reg) * PL'($signed({1'b0, ny_reg[L-1:0]}));
            pl_z_reg    <= PL'(s2_sz_reg) * PL'($signed({1'b0, nz_reg[L-1:0]}));
            ph_x_reg    <= PH'(s2_sx_reg) * PH'($signed(nx_reg[C-1:L]));
            ph_y_reg    <= PH'(s2_sy_reg) * PH'($signed(ny_reg[C-1:L]));
            ph_z_reg    <= PH'(s2_sz_reg) * PH'($signed(nz_reg[C-1:L]));
        end
    end

    // stage 4: inclusive range checks, partial sums
    logic                  v4_reg;
    logic signed [C:0]     uv_sum;
    logic                  un_ok, vn_ok;
    logic                  geom_ok_reg, s4_flip_reg, s4_last_reg;
    logic signed [T-1:0]   sum_lo_reg, sum_hi_reg;

    assign uv_sum = (C + 1)'(un_n_reg) + (C + 1)'(vn_n_reg);
    assign un_ok  = !un_n_reg[C-1] && (un_n_reg <= a_n_reg);
    assign vn_ok  = !vn_n_reg[C-1] && (uv_sum <= (C + 1)'(a_n_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            geom_ok_reg <= !a_zero_reg && un_ok && vn_ok;
            s4_flip_reg <= flip_reg;
            s4_last_reg <= s3_last_reg;
            sum_lo_reg  <= T'(pl_x_reg) + T'(pl_y_reg) + T'(pl_z_reg);
            sum_hi_reg  <= T'(ph_x_reg) + T'(ph_y_reg) + T'(ph_z_reg);
        end
    end

    // stage 5: rebuild s . n, strict sign test, parity update
    logic signed [T-1:0] tn;
    logic                tn_pos, tn_neg, hit;
    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_parity_reg, m_verdict_reg;
    logic                parity_reg, parity_next;
    logic                parity_out;

    assign tn     = (sum_hi_reg <<< L) + sum_lo_reg;
    assign tn_neg = tn[T-1];
    assign tn_pos = !tn[T-1] && (tn != '0);
    assign hit    = geom_ok_reg && (s4_flip_reg ? tn_neg : tn_pos);

    assign parity_out = parity_reg ^ hit;

    always_comb begin
        m_valid_next = m_valid_reg;
        parity_next  = parity_reg;
        if (en) begin
            m_valid_next = v4_reg;
            if (v4_reg) begin
                parity_next = s4_last_reg ? 1'b0 : parity_out;
            end
        end
    end

    // stage valids and crossing parity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            parity_reg  <= 1'b0;
        end else begin
            if (en) begin
                v1_reg <= !queue_stat.empty;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
            m_valid_reg <= m_valid_next;
            parity_reg  <= parity_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (en && v4_reg) begin
            m_hit_reg     <= hit;
            m_parity_reg  <= parity_out;
            m_verdict_reg <= s4_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_inside_parity = m_parity_reg;
    assign m_verdict_valid = m_verdict_reg;

endmodule

`default_nettype wire

### sv/point_in_mesh_ray_parity.sv
// ---------------------------------------------------------------------------
// point_in_mesh_ray_parity
// Ray-casting inside test of a point against a streamed triangle mesh.
// ---------------------------------------------------------------------------
// Load the query point through the register port (point_x at 0x0, point_y at
// 0x4, point_z at 0x8), then stream the mesh one triangle per transfer, with
// last_triangle set on the final one. Each triangle returns one result: hit
// when the +X ray from the point crosses it (edges and vertices count, a
// point lying on the triangle's plane does not, a degenerate triangle never
// hits), the running crossing parity, and verdict_valid on the last triangle,
// where inside_parity is the answer and the parity then restarts for the next
// mesh. The block takes one triangle per clock while the result output is not
// stalled; a result passes from the input register into the two-entry queue,
// from the queue into the back end, and through the multiply/add stages into
// the result register. There is no start-up sweep after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module point_in_mesh_ray_parity
    import pimrp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready,
    // triangle input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_v0_x,
    input  logic signed [COORD_BITS-1:0] s_v0_y,
    input  logic signed [COORD_BITS-1:0] s_v0_z,
    input  logic signed [COORD_BITS-1:0] s_v1_x,
    input  logic signed [COORD_BITS-1:0] s_v1_y,
    input  logic signed [COORD_BITS-1:0] s_v1_z,
    input  logic signed [COORD_BITS-1:0] s_v2_x,
    input  logic signed [COORD_BITS-1:0] s_v2_y,
    input  logic signed [COORD_BITS-1:0] s_v2_z,
    input  logic                         s_last_triangle,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic                         m_inside_parity,
    output logic                         m_verdict_valid
);

    localparam int ITEM_W = 9 * (COORD_BITS + 1) + 1;

    logic signed [COORD_BITS-1:0] point_x_reg, point_x_next;
    logic signed [COORD_BITS-1:0] point_y_reg, point_y_next;
    logic signed [COORD_BITS-1:0] point_z_reg, point_z_next;
    logic [CFG_IDX_W-1:0]         reg_idx;
    logic                         cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes; unmapped indexes are dropped
    always_comb begin
        point_x_next = point_x_reg;
        point_y_next = point_y_reg;
        point_z_next = point_z_reg;
        if (cfg_wr) begin
            unique case (reg_idx)
                REG_POINT_X: point_x_next = pwdata[COORD_BITS-1:0];
                REG_POINT_Y: point_y_next = pwdata[COORD_BITS-1:0];
                REG_POINT_Z: point_z_next = pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
            point_z_reg <= '0;
        end else begin
            point_x_reg <= point_x_next;
            point_y_reg <= point_y_next;
            point_z_reg <= point_z_next;
        end
    end

    // register read-back, sign-extended
    always_comb begin
        unique case (reg_idx)
            REG_POINT_X: prdata = CFG_DATA_W'(point_x_reg);
            REG_POINT_Y: prdata = CFG_DATA_W'(point_y_reg);
            REG_POINT_Z: prdata = CFG_DATA_W'(point_z_reg);
            default:     prdata = '0;
        endcase
    end

    // front end, queue, back end
    queue_stat_t       queue_stat;
    logic              push, pop;
    logic [ITEM_W-1:0] push_data, head_data;

    pimrp_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_v0_x          (s_v0_x),
        .s_v0_y          (s_v0_y),
        .s_v0_z          (s_v0_z),
        .s_v1_x          (s_v1_x),
        .s_v1_y          (s_v1_y),
        .s_v1_z          (s_v1_z),
        .s_v2_x          (s_v2_x),
        .s_v2_y          (s_v2_y),
        .s_v2_z          (s_v2_z),
        .s_last_triangle (s_last_triangle),
        .point_x         (point_x_reg),
        .point_y         (point_y_reg),
        .point_z         (point_z_reg),
        .queue_stat      (queue_stat),
        .push            (push),
        .push_data       (push_data)
    );

    pimrp_queue #(
        .ITEM_W(ITEM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .stat      (queue_stat)
    );

    pimrp_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .queue_stat      (queue_stat),
        .head_data       (head_data),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_inside_parity (m_inside_parity),
        .m_verdict_valid (m_verdict_valid)
    );

endmodule

`default_nettype wire

### sv/pimrp_checker.sv
// ---------------------------------------------------------------------------
// pimrp_checker
// Port-level checks: parity chain across results, no result without a
// triangle in flight, and a stalled result holding still.
// ---------------------------------------------------------------------------
`default_nettype none

`include "point_in_mesh_ray_parity_macros.svh"

module pimrp_checker (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_ready,
    input  wire logic m_valid,
    input  wire logic m_ready,
    input  wire logic m_hit,
    input  wire logic m_inside_parity,
    input  wire logic m_verdict_valid
);

    localparam int FLIGHT_W = 4;

    logic                in_xfer, out_xfer;
    logic                par_reg, par_next;
    logic [FLIGHT_W-1:0] flight_reg, flight_next;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    // shadow parity from delivered results
    always_comb begin
        par_next = par_reg;
        if (out_xfer) begin
            par_next = m_verdict_valid ? 1'b0 : m_inside_parity;
        end
    end

    // triangles taken but not yet answered
    always_comb begin
        flight_next = flight_reg;
        if (in_xfer && !out_xfer) begin
            flight_next = flight_reg + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            flight_next = flight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            par_reg    <= 1'b0;
            flight_reg <= '0;
        end else begin
            par_reg    <= par_next;
            flight_reg <= flight_next;
        end
    end

    `PIMRP_ASSERT_IMPL(a_parity_chain, m_valid, m_inside_parity == (par_reg ^ m_hit))
    `PIMRP_ASSERT_IMPL(a_no_phantom, m_valid, flight_reg != '0)
    `PIMRP_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_hit) && $stable(m_inside_parity) && $stable(m_verdict_valid))

endmodule

bind point_in_mesh_ray_parity pimrp_checker u_checker (.*);

`default_nettype wire
